/* hdl/let_pkg.sv */
// Shared constants and control types for the label equivalence table.
`timescale 1ns / 1ps

package let_pkg;

  localparam int MAX_LABELS = 1024;
  localparam int LABEL_W    = $clog2(MAX_LABELS);
  localparam int CNT_W      = $clog2(MAX_LABELS + 1);
  localparam int CHAIN_W    = CNT_W;

  localparam logic [CHAIN_W-1:0] CHAIN_END = CHAIN_W'(MAX_LABELS);

  localparam logic [1:0] OP_NEW_FRAME = 2'd0;
  localparam logic [1:0] OP_ALLOCATE  = 2'd1;
  localparam logic [1:0] OP_MERGE     = 2'd2;
  localparam logic [1:0] OP_LOOKUP    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic accept;   // take the input item
    logic resolve;  // representatives are read, decide the merge
    logic walk;     // re-point one chain member
    logic splice;   // link the absorbed chain to the kept tail
    logic emit;     // move the result into the output register
  } let_cmd_t;

  typedef struct packed {
    logic need_read;   // input item needs the representative store
    logic start_walk;  // merge of two different roots
    logic walk_done;   // end of the absorbed chain reached
    logic out_busy;    // output register holds an item not taken this cycle
  } let_sts_t;

endpackage

/* hdl/let_ctrl.sv */
// Sequencing state machine for the label equivalence table.
`timescale 1ns / 1ps

module let_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  let_pkg::let_sts_t sts_i,
  output let_pkg::let_cmd_t cmd_o
);
  import let_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_SPLICE = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.need_read ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        cmd_o.resolve = 1'b1;
        state_d       = sts_i.start_walk ? S_WALK : S_DONE;
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_done) begin
          state_d = S_SPLICE;
        end
      end
      S_SPLICE: begin
        cmd_o.splice = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/let_datapath.sv */
// Label stores, chain walker and output register of the label equivalence table.
`timescale 1ns / 1ps

module let_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [1:0]                operation_i,
  input  logic [let_pkg::LABEL_W-1:0] label_a_i,
  input  logic [let_pkg::LABEL_W-1:0] label_b_i,
  input  let_pkg::let_cmd_t         cmd_i,
  output let_pkg::let_sts_t         sts_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [let_pkg::LABEL_W-1:0] label_out_o,
  output logic [1:0]                status_o
);
  import let_pkg::*;

  logic [LABEL_W-1:0] rep_mem  [MAX_LABELS];
  logic [CHAIN_W-1:0] next_mem [MAX_LABELS];
  logic [LABEL_W-1:0] tail_mem [MAX_LABELS];

  logic [1:0]         op_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [LABEL_W-1:0] rep_a_q, rep_b_q;
  logic [LABEL_W-1:0] keep_q, root_v_q;
  logic [LABEL_W-1:0] tail_keep_q, tail_v_q;
  logic [CHAIN_W-1:0] next_q;
  logic               first_q;
  logic [CNT_W-1:0]   steps_q;
  logic [LABEL_W-1:0] res_label_q;
  logic [1:0]         res_status_q;
  logic               out_valid_q;
  logic [LABEL_W-1:0] label_out_q;
  logic [1:0]         status_q;

  logic               a_ok, b_ok, is_full, alloc_en, walk_en, walk_done;
  logic [LABEL_W-1:0] cnt_lbl, min_root, max_root, cur;

  assign cnt_lbl  = cnt_q[LABEL_W-1:0];
  assign a_ok     = {1'b0, label_a_i} < cnt_q;
  assign b_ok     = {1'b0, label_b_i} < cnt_q;
  assign is_full  = (cnt_q == CNT_W'(MAX_LABELS));
  assign alloc_en = cmd_i.accept && (operation_i == OP_ALLOCATE) && !is_full;

  assign min_root = (rep_a_q < rep_b_q) ? rep_a_q : rep_b_q;
  assign max_root = (rep_a_q < rep_b_q) ? rep_b_q : rep_a_q;

  // The first member is the absorbed root itself; later ones come straight
  // from the registered chain read, so the walk takes one member per cycle.
  assign cur       = first_q ? root_v_q : next_q[LABEL_W-1:0];
  assign walk_done = (!first_q && (next_q >= CHAIN_END)) ||
                     (steps_q == CNT_W'(MAX_LABELS));
  assign walk_en   = cmd_i.walk && !walk_done;

  assign sts_o.need_read  = ((operation_i == OP_MERGE) && a_ok && b_ok) ||
                            ((operation_i == OP_LOOKUP) && a_ok);
  assign sts_o.start_walk = (op_q == OP_MERGE) && (rep_a_q != rep_b_q);
  assign sts_o.walk_done  = walk_done;
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  // Representative store: two read ports, one write port.
  always_ff @(posedge clk_i) begin
    if (alloc_en) begin
      rep_mem[cnt_lbl] <= cnt_lbl;
    end else if (walk_en) begin
      rep_mem[cur] <= keep_q;
    end
    if (cmd_i.accept) begin
      rep_a_q <= rep_mem[label_a_i];
      rep_b_q <= rep_mem[label_b_i];
    end
  end

  // Chain link store.
  always_ff @(posedge clk_i) begin
    if (alloc_en) begin
      next_mem[cnt_lbl] <= CHAIN_END;
    end else if (cmd_i.splice) begin
      next_mem[tail_keep_q] <= CHAIN_W'(root_v_q);
    end
    if (walk_en) begin
      next_q <= next_mem[cur];
    end
  end

  // Chain tail store.
  always_ff @(posedge clk_i) begin
    if (alloc_en) begin
      tail_mem[cnt_lbl] <= cnt_lbl;
    end else if (cmd_i.splice) begin
      tail_mem[keep_q] <= tail_v_q;
    end
    if (cmd_i.resolve) begin
      tail_keep_q <= tail_mem[min_root];
      tail_v_q    <= tail_mem[max_root];
    end
  end

  // Item decode and pending result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= operation_i;
      case (operation_i)
        OP_NEW_FRAME: begin
          res_label_q  <= '0;
          res_status_q <= ST_OK;
        end
        OP_ALLOCATE: begin
          res_label_q  <= is_full ? '0 : cnt_lbl;
          res_status_q <= is_full ? ST_FULL : ST_OK;
        end
        default: begin
          res_label_q  <= '0;
          res_status_q <= ST_RANGE;
        end
      endcase
    end else if (cmd_i.resolve) begin
      res_label_q  <= (op_q == OP_LOOKUP) ? rep_a_q : min_root;
      res_status_q <= ST_OK;
      keep_q       <= min_root;
      root_v_q     <= max_root;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      first_q <= 1'b0;
      steps_q <= '0;
    end else begin
      if (cmd_i.accept && (operation_i == OP_NEW_FRAME)) begin
        cnt_q <= '0;
      end else if (alloc_en) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.resolve) begin
        first_q <= 1'b1;
        steps_q <= '0;
      end else if (walk_en) begin
        first_q <= 1'b0;
        steps_q <= steps_q + CNT_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      label_out_q <= res_label_q;
      status_q    <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign label_out_o = label_out_q;
  assign status_o    = status_q;

endmodule

/* hdl/label_equivalence_table_top.sv */
// Label equivalence table: operations in, one result item out per operation.
//
// Input channel (in_valid_i/in_ready_o) carries one operation per item:
// new frame, allocate, merge or lookup. Output channel (out_valid_o/
// out_ready_i) returns one item per operation with a label and a status.
// Items are handled one at a time; in_ready_o is high only while idle.
// The result of an item reaches the output register through these states
// after the item is accepted:
//   new frame, allocate and out-of-range errors: straight to done;
//   lookup and merge of labels that share a root: read, then done;
//   merge of two roots: read, then a walk of the absorbed root's chain,
//   one member per cycle through the registered chain link read, then
//   splice and done.
// The next item can be taken once a result is loaded into the output register.
// The block takes the next item as soon as it returns to idle, even while
// the previous result waits; that item then waits for the output register.
// If the receiver stalls, the result stays in the output register.
// Reset empties the table (label count zero); stored labels need no clear.
`timescale 1ns / 1ps

module label_equivalence_table_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  operation_i,
  input  logic [let_pkg::LABEL_W-1:0] label_a_i,
  input  logic [let_pkg::LABEL_W-1:0] label_b_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [let_pkg::LABEL_W-1:0] label_out_o,
  output logic [1:0]                  status_o
);
  import let_pkg::*;

  let_cmd_t cmd;
  let_sts_t sts;

  let_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  let_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .operation_i (operation_i),
    .label_a_i   (label_a_i),
    .label_b_i   (label_b_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .label_out_o (label_out_o),
    .status_o    (status_o)
  );

  // Every item keeps the block busy in the cycle after its acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken on two consecutive cycles");

  // Error results always carry label zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL || status_o == ST_RANGE)) |-> (label_out_o == '0))
    else $error("error result with nonzero label");

  // Only the three defined status codes are ever returned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_FULL || status_o == ST_RANGE))
    else $error("undefined status code");

  // A result is only loaded while the block is busy, never during idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && in_ready_o && !in_valid_i) |=> !out_valid_o)
    else $error("result produced without an item");

endmodule

/* dv/tb_label_equivalence_table_top.sv */
// Self-checking testbench for the label equivalence table: directed steps, then random frames.
`timescale 1ns / 1ps

module tb_label_equivalence_table_top;
  import let_pkg::*;

  localparam int DIR_N      = 23;
  localparam int ITEM_GOAL  = 1400;
  localparam int QUIET_TAIL = 150;
  localparam int DRAIN_CYC  = 40;
  localparam int LIMIT_CYC  = 6_000_000;

  typedef struct packed {
    logic [LABEL_W-1:0] lab;
    logic [1:0]         st;
  } result_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [LABEL_W-1:0] a;
    logic [LABEL_W-1:0] b;
    logic               typed;
    result_t            res;
  } step_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         operation_i;
  logic [LABEL_W-1:0] label_a_i;
  logic [LABEL_W-1:0] label_b_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [LABEL_W-1:0] label_out_o;
  logic [1:0]         status_o;

  label_equivalence_table_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .label_a_i   (label_a_i),
    .label_b_i   (label_b_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .label_out_o (label_out_o),
    .status_o    (status_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the table.
  logic [LABEL_W-1:0] root_of    [MAX_LABELS];
  logic [CHAIN_W-1:0] next_link  [MAX_LABELS];
  logic [LABEL_W-1:0] chain_last [MAX_LABELS];
  logic [CNT_W-1:0]   labels_used;

  result_t pending_q [$];
  int      err_cnt;
  int      sent_cnt;
  int      cycle_cnt;
  bit      idle_en;

  step_row_t dir_steps [DIR_N] = '{
    '{OP_LOOKUP,    10'd0,    10'd0,    1'b1, '{10'd0, ST_RANGE}},
    '{OP_MERGE,     10'd0,    10'd0,    1'b1, '{10'd0, ST_RANGE}},
    '{OP_ALLOCATE,  10'd1023, 10'd1023, 1'b1, '{10'd0, ST_OK}},
    '{OP_ALLOCATE,  10'd0,    10'd0,    1'b1, '{10'd1, ST_OK}},
    '{OP_ALLOCATE,  10'd5,    10'd9,    1'b1, '{10'd2, ST_OK}},
    '{OP_ALLOCATE,  10'd512,  10'd511,  1'b1, '{10'd3, ST_OK}},
    '{OP_LOOKUP,    10'd3,    10'd1023, 1'b1, '{10'd3, ST_OK}},
    '{OP_LOOKUP,    10'd4,    10'd0,    1'b1, '{10'd0, ST_RANGE}},
    '{OP_MERGE,     10'd1,    10'd0,    1'b0, '{10'd0, ST_OK}},
    '{OP_MERGE,     10'd3,    10'd2,    1'b0, '{10'd0, ST_OK}},
    '{OP_MERGE,     10'd2,    10'd1,    1'b0, '{10'd0, ST_OK}},
    '{OP_MERGE,     10'd0,    10'd3,    1'b0, '{10'd0, ST_OK}},
    '{OP_MERGE,     10'd1023, 10'd0,    1'b1, '{10'd0, ST_RANGE}},
    '{OP_MERGE,     10'd0,    10'd1023, 1'b1, '{10'd0, ST_RANGE}},
    '{OP_LOOKUP,    10'd1023, 10'd1023, 1'b1, '{10'd0, ST_RANGE}},
    '{OP_LOOKUP,    10'd2,    10'd0,    1'b0, '{10'd0, ST_OK}},
    '{OP_NEW_FRAME, 10'd1023, 10'd1023, 1'b1, '{10'd0, ST_OK}},
    '{OP_LOOKUP,    10'd0,    10'd0,    1'b1, '{10'd0, ST_RANGE}},
    '{OP_ALLOCATE,  10'd0,    10'd0,    1'b1, '{10'd0, ST_OK}},
    '{OP_ALLOCATE,  10'd0,    10'd0,    1'b1, '{10'd1, ST_OK}},
    '{OP_MERGE,     10'd1,    10'd1,    1'b0, '{10'd0, ST_OK}},
    '{OP_MERGE,     10'd0,    10'd1,    1'b0, '{10'd0, ST_OK}},
    '{OP_NEW_FRAME, 10'd0,    10'd0,    1'b1, '{10'd0, ST_OK}}
  };

  // Re-point every member of the chain rooted at gone, then hang it off keep's tail.
  function automatic void fold_root(input logic [LABEL_W-1:0] keep,
                                    input logic [LABEL_W-1:0] gone);
    logic [CHAIN_W-1:0] cur;
    int                 hops;
    cur  = CHAIN_W'(gone);
    hops = 0;
    while (cur < CHAIN_END && hops < MAX_LABELS) begin
      root_of[cur[LABEL_W-1:0]] = keep;
      cur = next_link[cur[LABEL_W-1:0]];
      hops++;
    end
    next_link[chain_last[keep]] = CHAIN_W'(gone);
    chain_last[keep] = chain_last[gone];
  endfunction

  function automatic result_t predict_result(input logic [1:0] op,
                                             input logic [LABEL_W-1:0] a,
                                             input logic [LABEL_W-1:0] b);
    result_t            r;
    logic [LABEL_W-1:0] ra;
    logic [LABEL_W-1:0] rb;
    r.lab = '0;
    r.st  = ST_OK;
    case (op)
      OP_NEW_FRAME: begin
        labels_used = '0;
      end
      OP_ALLOCATE: begin
        if (labels_used >= CNT_W'(MAX_LABELS)) begin
          r.st = ST_FULL;
        end else begin
          r.lab = labels_used[LABEL_W-1:0];
          root_of[r.lab]    = r.lab;
          next_link[r.lab]  = CHAIN_END;
          chain_last[r.lab] = r.lab;
          labels_used       = labels_used + CNT_W'(1);
        end
      end
      OP_MERGE: begin
        if (CNT_W'(a) >= labels_used || CNT_W'(b) >= labels_used) begin
          r.st = ST_RANGE;
        end else begin
          ra = root_of[a];
          rb = root_of[b];
          if (ra < rb) begin
            fold_root(ra, rb);
            r.lab = ra;
          end else if (ra > rb) begin
            fold_root(rb, ra);
            r.lab = rb;
          end else begin
            r.lab = ra;
          end
        end
      end
      default: begin
        if (CNT_W'(a) >= labels_used) r.st = ST_RANGE;
        else r.lab = root_of[a];
      end
    endcase
    return r;
  endfunction

  function automatic logic [LABEL_W-1:0] any_label();
    return LABEL_W'($urandom_range(0, MAX_LABELS - 1));
  endfunction

  // Present one item and hold it until taken. Valid is left high so that the
  // next item can follow without a gap; it drops only when a gap is chosen.
  task automatic issue_op(input logic [1:0] op, input logic [LABEL_W-1:0] a,
                          input logic [LABEL_W-1:0] b, input bit typed = 1'b0,
                          input result_t typed_res = '0);
    int      gap;
    result_t r;
    if (sent_cnt >= ITEM_GOAL - QUIET_TAIL) idle_en = 1'b0;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    label_a_i   <= a;
    label_b_i   <= b;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_result(op, a, b);
    pending_q.insert(pending_q.size(), typed ? typed_res : r);
    sent_cnt++;
  endtask

  task automatic run_frame(input int n_alloc, input int n_ops, input bit clear);
    int                 i;
    int                 pick;
    int                 top;
    logic [LABEL_W-1:0] a;
    logic [LABEL_W-1:0] b;
    logic [LABEL_W-1:0] bad;
    if (clear) issue_op(OP_NEW_FRAME, any_label(), any_label());
    for (i = 0; i < n_alloc; i++) issue_op(OP_ALLOCATE, any_label(), any_label());
    for (i = 0; i < n_ops; i++) begin
      pick = $urandom_range(0, 99);
      top  = (labels_used == '0) ? 0 : int'(labels_used) - 1;
      a    = LABEL_W'($urandom_range(0, top));
      b    = LABEL_W'($urandom_range(0, top));
      bad  = (int'(labels_used) < MAX_LABELS) ?
             LABEL_W'($urandom_range(int'(labels_used), MAX_LABELS - 1)) : any_label();
      if (pick < 60) begin
        issue_op(OP_MERGE, a, b);
      end else if (pick < 80) begin
        issue_op(OP_LOOKUP, a, any_label());
      end else if (pick < 84) begin
        issue_op(OP_MERGE, bad, b);
      end else if (pick < 88) begin
        issue_op(OP_MERGE, a, bad);
      end else if (pick < 91) begin
        issue_op(OP_LOOKUP, bad, any_label());
      end else if (pick < 97) begin
        issue_op(OP_ALLOCATE, any_label(), any_label());
      end else begin
        issue_op(2'($urandom_range(0, 3)), any_label(), any_label());
      end
    end
  endtask

  task automatic note_mismatch(input string what, input result_t exp, input result_t got);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%0t: %s: expected label %0d status %0d, got label %0d status %0d",
               $time, what, exp.lab, exp.st, got.lab, got.st);
    end
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.lab = label_out_o;
      got.st  = status_o;
      if (pending_q.size() == 0) begin
        note_mismatch("result with no item outstanding", '0, got);
      end else begin
        exp = pending_q.pop_front();
        if (got.lab !== exp.lab || got.st !== exp.st) note_mismatch("result", exp, got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYC) begin
      $display("tb_label_equivalence_table_top: errors");
      $finish;
    end
  end

  // Receiver side: random stall bursts while idling is enabled.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    int i;
    int f;
    int n_alloc;
    err_cnt     = 0;
    sent_cnt    = 0;
    cycle_cnt   = 0;
    idle_en     = 1'b1;
    labels_used = '0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    operation_i <= OP_NEW_FRAME;
    label_a_i   <= '0;
    label_b_i   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_N; i++) begin
      issue_op(dir_steps[i].op, dir_steps[i].a, dir_steps[i].b,
               dir_steps[i].typed, dir_steps[i].res);
    end

    // Frame two fills the table past its limit, so allocations come back full.
    for (f = 0; sent_cnt < ITEM_GOAL; f++) begin
      idle_en = (sent_cnt < ITEM_GOAL - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      if (f == 2) begin
        run_frame(MAX_LABELS + 3, 60, 1'b1);
      end else begin
        n_alloc = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200) :
                                                $urandom_range(2, 24);
        run_frame(n_alloc, $urandom_range(10, 50), $urandom_range(0, 7) != 0);
      end
    end

    idle_en = 1'b0;
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_label_equivalence_table_top: clean");
    end else begin
      $display("tb_label_equivalence_table_top: errors");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/let_pkg.sv
hdl/let_ctrl.sv
hdl/let_datapath.sv
hdl/label_equivalence_table_top.sv
dv/tb_label_equivalence_table_top.sv
